[rtl/core/lpfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpfd_pkg: shared types and constants for the length-prefixed frame deframer
// Word codes, result kinds, error codes and header byte positions.
// ----------------------------------------------------------------------------
package lpfd_pkg;

  typedef enum logic {
    OP_DATA  = 1'b0,
    OP_RESET = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2,
    KIND_ABORT   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_LEN_SHORT = 2'd0,
    ERR_LEN_LONG  = 2'd1,
    ERR_FLAGS     = 2'd2,
    ERR_REJECTED  = 2'd3
  } err_t;

  localparam logic [31:0] MAX_LEN_RESET = 32'd65536;
  localparam logic [31:0] MIN_LEN       = 32'd4;   // opcode + flags words

  // Header byte positions (header_count values)
  localparam logic [2:0] HDR_LEN_LAST   = 3'd3;
  localparam logic [2:0] HDR_OP_FIRST   = 3'd4;
  localparam logic [2:0] HDR_OP_LAST    = 3'd5;
  localparam logic [2:0] HDR_FLAGS_LAST = 3'd7;

endpackage
`default_nettype wire

[rtl/core/lpfd_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpfd_in_if: input word channel
// Valid/ready channel carrying one stream byte or a decoder reset.
// ----------------------------------------------------------------------------
interface lpfd_in_if
  import lpfd_pkg::*;
();
  logic       valid;
  logic       ready;
  op_t        op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface
`default_nettype wire

[rtl/core/lpfd_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpfd_out_if: result word channel
// Valid/ready channel carrying payload bytes, markers and errors.
// ----------------------------------------------------------------------------
interface lpfd_out_if
  import lpfd_pkg::*;
();
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [15:0] frame_opcode;
  logic [7:0]  payload_byte;
  logic        last_of_frame;
  err_t        error_code;

  modport source (output valid, output kind, output frame_opcode, output payload_byte,
                  output last_of_frame, output error_code, input ready);
  modport sink   (input valid, input kind, input frame_opcode, input payload_byte,
                  input last_of_frame, input error_code, output ready);
endinterface
`default_nettype wire

[rtl/core/length_prefixed_frame_deframer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer: byte stream to tagged payload words
// Parses [len32 LE][opcode16 LE][flags16 LE][payload] frames, one byte per
// word, and emits payload bytes tagged with the opcode, markers and errors.
// ----------------------------------------------------------------------------
// Output: a result appears on out_ch in the cycle after its input word is taken.
// Throughput: one input word per cycle; the single result register is the
//   only pipeline stage, and in_ch.ready stays high while it is empty or
//   being drained in the same cycle.
// Reset: rst_n is synchronous, active low; clears parser state, rejection,
//   the output valid flag, and restores max_frame_length to 65536.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer
  import lpfd_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  lpfd_in_if.sink     in_ch,
  lpfd_out_if.source  out_ch,
  input  wire         cfg_we,
  input  wire  [31:0] cfg_wdata
);

  // --------------------------------------------------------------------------
  // Configuration: frame length limit
  // --------------------------------------------------------------------------
  logic [31:0] max_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Parser state
  // --------------------------------------------------------------------------
  logic        in_payload_r, in_payload_nxt;
  logic [2:0]  hdr_cnt_r,    hdr_cnt_nxt;    // header bytes seen
  logic [31:0] len_r,        len_nxt;
  logic [15:0] opcode_r,     opcode_nxt;
  logic [15:0] flags_r,      flags_nxt;
  logic [31:0] remain_r,     remain_nxt;     // payload bytes still to come
  logic        rejected_r,   rejected_nxt;   // sticky stream rejection

  // Result produced by the current word
  logic        res_valid;
  kind_t       res_kind;
  logic [15:0] res_opcode;
  logic [7:0]  res_byte;
  logic        res_last;
  err_t        res_err;

  // Output register
  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [15:0] out_opcode_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;
  err_t        out_err_r;

  logic        in_fire;
  logic [31:0] remain_dec;
  logic [31:0] len_body;     // payload length once the header is complete
  logic        mid_frame;

  // Take a word whenever the result register is free or draining now.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign remain_dec = remain_r - 32'd1;
  assign len_body   = len_r - MIN_LEN;
  assign mid_frame  = in_payload_r || (hdr_cnt_r != 3'd0);

  // --------------------------------------------------------------------------
  // Next-state and result logic for one word
  // --------------------------------------------------------------------------
  always_comb begin
    in_payload_nxt = in_payload_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    len_nxt        = len_r;
    opcode_nxt     = opcode_r;
    flags_nxt      = flags_r;
    remain_nxt     = remain_r;
    rejected_nxt   = rejected_r;

    res_valid  = 1'b0;
    res_kind   = KIND_PAYLOAD;
    res_opcode = 16'd0;
    res_byte   = 8'd0;
    res_last   = 1'b0;
    res_err    = ERR_LEN_SHORT;

    if (in_ch.op == OP_RESET) begin
      // Decoder reset: clear everything; abort marker if a frame was open
      in_payload_nxt = 1'b0;
      hdr_cnt_nxt    = 3'd0;
      len_nxt        = 32'd0;
      opcode_nxt     = 16'd0;
      flags_nxt      = 16'd0;
      remain_nxt     = 32'd0;
      rejected_nxt   = 1'b0;
      if (mid_frame) begin
        res_valid  = 1'b1;
        res_kind   = KIND_ABORT;
        res_opcode = opcode_r;
      end
    end else if (rejected_r) begin
      res_valid = 1'b1;
      res_kind  = KIND_ERROR;
      res_err   = ERR_REJECTED;
    end else if (in_payload_r) begin
      res_valid  = 1'b1;
      res_kind   = KIND_PAYLOAD;
      res_opcode = opcode_r;
      res_byte   = in_ch.data_byte;
      remain_nxt = remain_dec;
      if (remain_dec == 32'd0) begin
        res_last       = 1'b1;
        in_payload_nxt = 1'b0;
        hdr_cnt_nxt    = 3'd0;
        len_nxt        = 32'd0;
        opcode_nxt     = 16'd0;
        flags_nxt      = 16'd0;
      end
    end else begin
      hdr_cnt_nxt = hdr_cnt_r + 3'd1;
      if (hdr_cnt_r <= HDR_LEN_LAST) begin
        // Length bytes, little endian
        len_nxt[{hdr_cnt_r[1:0], 3'b000} +: 8] =
          len_r[{hdr_cnt_r[1:0], 3'b000} +: 8] | in_ch.data_byte;
        if (hdr_cnt_r == HDR_LEN_LAST) begin
          if ((len_nxt < MIN_LEN) || (len_nxt > max_len_r)) begin
            res_valid      = 1'b1;
            res_kind       = KIND_ERROR;
            res_opcode     = opcode_r;
            res_err        = (len_nxt < MIN_LEN) ? ERR_LEN_SHORT : ERR_LEN_LONG;
            rejected_nxt   = 1'b1;
            in_payload_nxt = 1'b0;
            hdr_cnt_nxt    = 3'd0;
            len_nxt        = 32'd0;
            opcode_nxt     = 16'd0;
            flags_nxt      = 16'd0;
            remain_nxt     = 32'd0;
          end
        end
      end else if (hdr_cnt_r <= HDR_OP_LAST) begin
        // Opcode bytes: position 4 is low byte, 5 is high byte
        opcode_nxt[{hdr_cnt_r[0], 3'b000} +: 8] =
          opcode_r[{hdr_cnt_r[0], 3'b000} +: 8] | in_ch.data_byte;
      end else begin
        // Flags bytes: position 6 is low byte, 7 is high byte
        flags_nxt[{hdr_cnt_r[0], 3'b000} +: 8] =
          flags_r[{hdr_cnt_r[0], 3'b000} +: 8] | in_ch.data_byte;
        if (hdr_cnt_r == HDR_FLAGS_LAST) begin
          hdr_cnt_nxt = 3'd0;
          if (flags_nxt != 16'd0) begin
            res_valid      = 1'b1;
            res_kind       = KIND_ERROR;
            res_opcode     = opcode_r;
            res_err        = ERR_FLAGS;
            rejected_nxt   = 1'b1;
            in_payload_nxt = 1'b0;
            len_nxt        = 32'd0;
            opcode_nxt     = 16'd0;
            flags_nxt      = 16'd0;
            remain_nxt     = 32'd0;
          end else if (len_body == 32'd0) begin
            // Header-only frame: single marker
            res_valid  = 1'b1;
            res_kind   = KIND_EMPTY;
            res_opcode = opcode_r;
            res_last   = 1'b1;
            len_nxt    = 32'd0;
            opcode_nxt = 16'd0;
            flags_nxt  = 16'd0;
            remain_nxt = 32'd0;
          end else begin
            in_payload_nxt = 1'b1;
            remain_nxt     = len_body;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // State registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r <= 1'b0;
      hdr_cnt_r    <= 3'd0;
      len_r        <= 32'd0;
      opcode_r     <= 16'd0;
      flags_r      <= 16'd0;
      remain_r     <= 32'd0;
      rejected_r   <= 1'b0;
    end else if (in_fire) begin
      in_payload_r <= in_payload_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      len_r        <= len_nxt;
      opcode_r     <= opcode_nxt;
      flags_r      <= flags_nxt;
      remain_r     <= remain_nxt;
      rejected_r   <= rejected_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_kind_r   <= res_kind;
      out_opcode_r <= res_opcode;
      out_byte_r   <= res_byte;
      out_last_r   <= res_last;
      out_err_r    <= res_err;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = out_kind_r;
  assign out_ch.frame_opcode  = out_opcode_r;
  assign out_ch.payload_byte  = out_byte_r;
  assign out_ch.last_of_frame = out_last_r;
  assign out_ch.error_code    = out_err_r;

endmodule
`default_nettype wire

[rtl/core/lpfd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpfd_checker: port-level checks for the deframer
// Result word consistency and output hold under backpressure.
// ----------------------------------------------------------------------------
module lpfd_checker
  import lpfd_pkg::*;
(
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire [1:0]  out_kind,
  input wire [15:0] out_opcode,
  input wire [7:0]  out_byte,
  input wire        out_last,
  input wire [1:0]  out_err
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_opcode)
      && $stable(out_byte) && $stable(out_last) && $stable(out_err))
    else $error("result word changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_ERROR) |-> out_err == ERR_LEN_SHORT)
    else $error("error code set on non-error word");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_PAYLOAD) |-> out_byte == 8'd0)
    else $error("payload byte set on non-payload word");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> (out_kind == KIND_PAYLOAD) || (out_kind == KIND_EMPTY))
    else $error("last flag on marker or error word");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_EMPTY) |-> out_last)
    else $error("empty frame marker without last flag");

endmodule

bind length_prefixed_frame_deframer lpfd_checker u_lpfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_kind   (out_ch.kind),
  .out_opcode (out_ch.frame_opcode),
  .out_byte   (out_ch.payload_byte),
  .out_last   (out_ch.last_of_frame),
  .out_err    (out_ch.error_code)
);
`default_nettype wire
